FILE: design/aging_learning_table_core_macros.svh
// Assertion macros for the aging learning table
`ifndef AGING_LEARNING_TABLE_CORE_MACROS_SVH
`define AGING_LEARNING_TABLE_CORE_MACROS_SVH
`define ALT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ALT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/alt_pkg.sv
// Shared types and constants for the aging learning table
package alt_pkg;
  localparam int TableEntries = 32;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int EntryW = 64 + 64 + 16 + 32 + 32 + 32 + 1;

  localparam logic [1:0] ActRecord = 2'd0;
  localparam logic [1:0] ActList = 2'd1;
  localparam logic [1:0] ActClear = 2'd2;

  localparam logic [2:0] StNew = 3'd0;
  localparam logic [2:0] StRefresh = 3'd1;
  localparam logic [2:0] StReplace = 3'd2;
  localparam logic [2:0] StIgnored = 3'd3;
  localparam logic [2:0] StRejected = 3'd4;
  localparam logic [2:0] StEntry = 3'd5;
  localparam logic [2:0] StEmpty = 3'd6;
  localparam logic [2:0] StCleared = 3'd7;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [15:0] port;
    logic [31:0] address;
    logic [31:0] first_time;
    logic [31:0] last_time;
    logic adopted;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_WRITE, S_EXP_RD, S_EXP_CHK, S_EXP_MRD,
    S_EXP_MOVE, S_LIST_RD, S_LIST_OUT, S_RESP
  } state_t;
endpackage

FILE: design/alt_ram.sv
// Generic single-port-write, registered-read RAM
module alt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/aging_learning_table_core.sv
// Aging learning table top level: entry RAM and sequencer
// channel | dir | handshake       | payload
// in      | in  | in_valid/stall  | action, key, time, port, address, flags
// out     | out | out_valid/stall | status, entry fields, entry_total, last
// cfg     | in  | cfg_valid/ready | ttl_seconds
// Record: a rejected or ignored record goes straight to the response; else the
// entries are scanned and the entry written. List: each expired entry is first
// replaced by the last entry, then each kept entry is listed; each result waits
// while out_stall is high. One item at a time: in_stall stays high until idle.
// Sync reset clears count and sets ttl=300; no clear pass.
module aging_learning_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [31:0] now_time,
  input  logic        adopted_here,
  input  logic [15:0] port,
  input  logic [31:0] src_address,
  input  logic        foreign_adopted,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] out_key_high,
  output logic [63:0] out_key_low,
  output logic [15:0] out_port,
  output logic [31:0] out_address,
  output logic [31:0] out_first_time,
  output logic [31:0] out_last_time,
  output logic        out_foreign_adopted,
  output logic [5:0]  entry_total,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import alt_pkg::*;

  state_t state, state_next;
  logic [CntW-1:0] count;
  logic [IdxW-1:0] idx, pick;
  logic [31:0] best;
  logic [15:0] ttl;
  logic [63:0] kh, kl;
  logic [31:0] now, ip;
  logic [15:0] prt;
  logic ado, foreign_flag, fresh;
  logic [IdxW-1:0] widx;
  logic [2:0] st;

  logic ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, rd, hold;

  alt_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rd)
  );

  logic [31:0] age;
  logic is_last;
  assign age = now - rd.last_time;
  assign is_last = ({1'b0, idx} + 1'b1) == count;

  assign cfg_ready = (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        case (action)
          ActRecord: state_next = S_SCAN_RD;
          ActList: state_next = S_EXP_RD;
          ActClear: state_next = S_RESP;
          default: state_next = S_IDLE;
        endcase
      end
      S_SCAN_RD: begin
        if (kh == '0 && kl == '0) state_next = S_RESP;
        else if (ado) state_next = S_RESP;
        else if (count == '0) state_next = S_WRITE;
        else state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd.key_high == kh && rd.key_low == kl) state_next = S_WRITE;
        else if (is_last) state_next = S_WRITE;
        else state_next = S_SCAN_CHK;
      end
      S_WRITE: state_next = S_RESP;
      S_EXP_RD: state_next = (count == '0) ? S_RESP : S_EXP_CHK;
      S_EXP_CHK: begin
        if (age > {16'd0, ttl}) state_next = S_EXP_MRD;
        else if (is_last) state_next = S_LIST_RD;
        else state_next = S_EXP_CHK;
      end
      S_EXP_MRD: state_next = S_EXP_MOVE;
      S_EXP_MOVE: begin
        if ({1'b0, idx} >= count) state_next = (count == '0) ? S_RESP : S_LIST_RD;
        else state_next = S_EXP_RD;
      end
      S_LIST_RD: state_next = S_LIST_OUT;
      S_LIST_OUT: if (!out_stall) state_next = is_last ? S_IDLE : S_LIST_OUT;
      S_RESP: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_raddr = idx;
    if ((state == S_EXP_CHK && age > {16'd0, ttl}) || state == S_EXP_MRD)
      ram_raddr = IdxW'(count - 1'b1);
    else if ((state == S_SCAN_CHK || state == S_EXP_CHK) && !is_last)
      ram_raddr = idx + 1'b1;
    else if (state == S_EXP_CHK || state == S_EXP_MOVE) ram_raddr = '0;
    else if (state == S_LIST_OUT) ram_raddr = out_stall ? idx : idx + 1'b1;
    else if (state == S_IDLE) ram_raddr = '0;
    ram_we = 1'b0;
    ram_waddr = widx;
    ram_wdata = '{key_high: kh, key_low: kl, port: prt, address: ip,
                  first_time: fresh ? now : hold.first_time, last_time: now,
                  adopted: foreign_flag};
    if (state == S_WRITE) ram_we = 1'b1;
    if (state == S_EXP_MOVE) begin
      ram_we = 1'b1;
      ram_waddr = idx;
      ram_wdata = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ttl <= 16'd300;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) ttl <= cfg_data;
      case (state)
        S_IDLE: if (in_valid) begin
          kh <= key_high; kl <= key_low; now <= now_time;
          ado <= adopted_here; prt <= port; ip <= src_address;
          foreign_flag <= foreign_adopted;
          idx <= '0; pick <= '0; best <= '0;
          if (action == ActClear) begin
            count <= '0; st <= StCleared;
          end
        end
        S_SCAN_RD: begin
          if (kh == '0 && kl == '0) st <= StRejected;
          else if (ado) st <= StIgnored;
          else if (count == '0) begin
            widx <= '0; fresh <= 1'b1; st <= StNew; count <= count + 1'b1;
          end
        end
        S_SCAN_CHK: begin
          if (rd.key_high == kh && rd.key_low == kl) begin
            widx <= idx; fresh <= 1'b0; hold <= rd; st <= StRefresh;
          end else if (is_last) begin
            fresh <= 1'b1;
            if (count < CntW'(TableEntries)) begin
              widx <= IdxW'(count); count <= count + 1'b1; st <= StNew;
            end else begin
              st <= StReplace;
              widx <= (idx == '0 || age > best) ? idx : pick;
            end
          end else begin
            if (idx == '0 || age > best) begin
              best <= age; pick <= idx;
            end
            idx <= idx + 1'b1;
          end
        end
        S_EXP_RD: if (count == '0) st <= StEmpty;
        S_EXP_CHK: begin
          if (age > {16'd0, ttl}) ;
          else if (is_last) idx <= '0;
          else idx <= idx + 1'b1;
        end
        S_EXP_MRD: count <= count - 1'b1;
        S_EXP_MOVE: begin
          if ({1'b0, idx} >= count) begin
            idx <= '0;
            if (count == '0) st <= StEmpty;
          end
        end
        S_LIST_OUT: if (!out_stall) idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid = (state == S_RESP) || (state == S_LIST_OUT);
    status = (state == S_LIST_OUT) ? StEntry : st;
    entry_total = 6'(count);
    last = (state == S_RESP) || is_last;
    out_key_high = '0; out_key_low = '0; out_port = '0; out_address = '0;
    out_first_time = '0; out_last_time = '0; out_foreign_adopted = 1'b0;
    if (state == S_LIST_OUT) begin
      out_key_high = rd.key_high; out_key_low = rd.key_low; out_port = rd.port;
      out_address = rd.address; out_first_time = rd.first_time;
      out_last_time = rd.last_time; out_foreign_adopted = rd.adopted;
    end
  end
endmodule

FILE: design/alt_checker.sv
// Port-level checker for the aging learning table, bound to the top level
`include "aging_learning_table_core_macros.svh"
module alt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [5:0] entry_total,
  input logic       last,
  input logic       cfg_ready
);
  import alt_pkg::*;
  `ALT_ASSERT_IMPL(a_total_range, clk, rst, out_valid, entry_total <= 6'(TableEntries), "total")
  `ALT_ASSERT_IMPL(a_single_last, clk, rst, out_valid && status != StEntry, last, "not last")
  `ALT_ASSERT_IMPL(a_busy_no_cfg, clk, rst, out_valid, !cfg_ready, "cfg ready while busy")
  `ALT_ASSERT_IMPL(a_take_idle, clk, rst, in_valid && !in_stall, !out_valid && cfg_ready, "busy")
  `ALT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status), "hold")
endmodule

bind aging_learning_table_core alt_checker u_alt_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status),
  .entry_total(entry_total), .last(last), .cfg_ready(cfg_ready)
);

FILE: tb/sv/alt_table_checker.sv
// Checker for the aging learning table: predicts each item and compares results
module alt_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  action,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [31:0] now_time,
  input  logic        adopted_here,
  input  logic [15:0] port,
  input  logic [31:0] src_address,
  input  logic        foreign_adopted,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [63:0] out_key_high,
  input  logic [63:0] out_key_low,
  input  logic [15:0] out_port,
  input  logic [31:0] out_address,
  input  logic [31:0] out_first_time,
  input  logic [31:0] out_last_time,
  input  logic        out_foreign_adopted,
  input  logic [5:0]  entry_total,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import alt_pkg::*;

  typedef struct {
    logic [2:0]  code;
    entry_t      ent;
    logic [5:0]  total;
    logic        fin;
  } table_result_t;

  table_result_t expected_results[$];
  entry_t        table_mem[TableEntries];
  int unsigned   live_count;
  logic [15:0]   ttl;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void push_result(input logic [2:0] code, input int slot, input logic fin);
    table_result_t r;
    r.code = code;
    r.ent = '0;
    if (slot >= 0) begin
      r.ent = table_mem[slot];
    end
    r.total = live_count[5:0];
    r.fin = fin;
    expected_results.push_back(r);
  endfunction

  function automatic void apply_item();
    entry_t      fresh;
    int          hit;
    int          pick;
    int unsigned i;
    logic [31:0] age;
    logic [31:0] best;
    fresh.key_high = key_high;
    fresh.key_low = key_low;
    fresh.port = port;
    fresh.address = src_address;
    fresh.first_time = now_time;
    fresh.last_time = now_time;
    fresh.adopted = foreign_adopted;
    case (action)
      ActRecord: begin
        if (key_high == '0 && key_low == '0) begin
          push_result(StRejected, -1, 1'b1);
        end else if (adopted_here) begin
          push_result(StIgnored, -1, 1'b1);
        end else begin
          hit = -1;
          for (i = 0; i < live_count; i++) begin
            if (hit < 0 && table_mem[i].key_high == key_high &&
                table_mem[i].key_low == key_low) begin
              hit = i;
            end
          end
          if (hit >= 0) begin
            fresh.first_time = table_mem[hit].first_time;
            table_mem[hit] = fresh;
            push_result(StRefresh, -1, 1'b1);
          end else if (live_count < TableEntries) begin
            table_mem[live_count] = fresh;
            live_count++;
            push_result(StNew, -1, 1'b1);
          end else begin
            pick = 0;
            best = now_time - table_mem[0].last_time;
            for (i = 1; i < TableEntries; i++) begin
              age = now_time - table_mem[i].last_time;
              if (age > best) begin
                best = age;
                pick = i;
              end
            end
            table_mem[pick] = fresh;
            push_result(StReplace, -1, 1'b1);
          end
        end
      end
      ActList: begin
        i = 0;
        while (i < live_count) begin
          age = now_time - table_mem[i].last_time;
          if (age > {16'd0, ttl}) begin
            table_mem[i] = table_mem[live_count - 1];
            live_count--;
          end else begin
            i++;
          end
        end
        if (live_count == 0) begin
          push_result(StEmpty, -1, 1'b1);
        end else begin
          for (i = 0; i < live_count; i++) begin
            push_result(StEntry, i, i + 1 == live_count);
          end
        end
      end
      ActClear: begin
        live_count = 0;
        push_result(StCleared, -1, 1'b1);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    table_result_t w;
    if (rst) begin
      live_count = 0;
      ttl = 16'd300;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        ttl = cfg_data;
      end
      if (in_valid && !in_stall) begin
        apply_item();
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected result, status", 64'(status), 64'd0);
        end else begin
          w = expected_results.pop_front();
          if (status !== w.code) report("status", 64'(status), 64'(w.code));
          if (out_key_high !== w.ent.key_high) begin
            report("key_high", out_key_high, w.ent.key_high);
          end
          if (out_key_low !== w.ent.key_low) report("key_low", out_key_low, w.ent.key_low);
          if (out_port !== w.ent.port) report("port", 64'(out_port), 64'(w.ent.port));
          if (out_address !== w.ent.address) begin
            report("address", 64'(out_address), 64'(w.ent.address));
          end
          if (out_first_time !== w.ent.first_time) begin
            report("first time", 64'(out_first_time), 64'(w.ent.first_time));
          end
          if (out_last_time !== w.ent.last_time) begin
            report("last time", 64'(out_last_time), 64'(w.ent.last_time));
          end
          if (out_foreign_adopted !== w.ent.adopted) begin
            report("foreign adopted", 64'(out_foreign_adopted), 64'(w.ent.adopted));
          end
          if (entry_total !== w.total) begin
            report("entry_total", 64'(entry_total), 64'(w.total));
          end
          if (last !== w.fin) report("last", 64'(last), 64'(w.fin));
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the aging learning table: stimulus, reset and verdict
module tb;
  import alt_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int PoolSize = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [31:0] now_time;
  logic        adopted_here;
  logic [15:0] port;
  logic [31:0] src_address;
  logic        foreign_adopted;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [63:0] out_key_high;
  logic [63:0] out_key_low;
  logic [15:0] out_port;
  logic [31:0] out_address;
  logic [31:0] out_first_time;
  logic [31:0] out_last_time;
  logic        out_foreign_adopted;
  logic [5:0]  entry_total;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;

  logic          quiet = 1'b0;
  logic [127:0]  key_pool[PoolSize];
  logic [31:0]   clock_now;

  aging_learning_table_core dut (.*);

  alt_table_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #24000000;
    $display("FAIL");
    $finish;
  end

  // receiver: random stall before each result
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 4);
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [127:0] key, input logic [31:0] t,
                           input logic here, input logic [15:0] p, input logic [31:0] ip,
                           input logic elsewhere);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    action <= act;
    key_high <= key[127:64];
    key_low <= key[63:0];
    now_time <= t;
    adopted_here <= here;
    port <= p;
    src_address <= ip;
    foreign_adopted <= elsewhere;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    logic [127:0] k;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) begin
      clock_now = $urandom;
    end else begin
      clock_now = clock_now + $urandom_range(0, 20);
    end
    k = key_pool[$urandom_range(0, PoolSize - 1)];
    if (r < 68) begin
      send_item(ActRecord, k, clock_now, 1'b0, 16'($urandom), $urandom,
                1'($urandom_range(0, 1)));
    end else if (r < 72) begin
      send_item(ActRecord, '0, clock_now, 1'($urandom_range(0, 1)), 16'($urandom), $urandom,
                1'($urandom_range(0, 1)));
    end else if (r < 77) begin
      send_item(ActRecord, k, clock_now, 1'b1, 16'($urandom), $urandom,
                1'($urandom_range(0, 1)));
    end else if (r < 80) begin
      send_item(ActRecord, {$urandom, $urandom, $urandom, $urandom}, clock_now,
                1'b0, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
    end else if (r < 95) begin
      send_item(ActList, {$urandom, $urandom, $urandom, $urandom}, clock_now,
                1'($urandom_range(0, 1)), 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
    end else if (r < 98) begin
      send_item(ActClear, k, clock_now, 1'b0, 16'($urandom), $urandom, 1'b0);
    end else begin
      send_item(ActUnused, k, clock_now, 1'b0, 16'($urandom), $urandom, 1'b0);
    end
  endtask

  initial begin
    logic [15:0] ttl_plan[6];
    quiet = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    action <= ActRecord;
    key_high <= '0;
    key_low <= '0;
    now_time <= '0;
    adopted_here <= 1'b0;
    port <= '0;
    src_address <= '0;
    foreign_adopted <= 1'b0;
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = {$urandom, $urandom, $urandom, $urandom};
    end
    key_pool[0] = '1;
    key_pool[1] = 128'd1;
    key_pool[2] = {64'd1, 64'd0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: precedence, refresh, expiry boundary, wrap, clear, unused action
    send_item(ActRecord, '0, 32'd1000, 1'b0, 16'd1, 32'd1, 1'b0);
    send_item(ActRecord, '0, 32'd1000, 1'b1, 16'd1, 32'd1, 1'b1);
    send_item(ActList, '0, 32'd1000, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActRecord, key_pool[0], 32'd1000, 1'b1, 16'd5, 32'd5, 1'b0);
    send_item(ActRecord, key_pool[0], 32'd1000, 1'b0, 16'hffff, 32'hffffffff, 1'b1);
    send_item(ActRecord, key_pool[1], 32'd1000, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActRecord, key_pool[2], 32'd1000, 1'b0, 16'h1234, 32'h0a000001, 1'b0);
    send_item(ActRecord, key_pool[0], 32'd1005, 1'b0, 16'h8000, 32'h80000000, 1'b0);
    send_item(ActList, '0, 32'd1300, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActList, '0, 32'd1301, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActUnused, key_pool[3], 32'd1302, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActList, '0, 32'd1302, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActClear, '0, 32'd1303, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActList, '0, 32'd1303, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActRecord, key_pool[3], 32'hffffffff, 1'b0, 16'd7, 32'd7, 1'b0);
    send_item(ActRecord, key_pool[4], 32'hfffffffe, 1'b0, 16'd8, 32'd8, 1'b1);
    send_item(ActList, '0, 32'd5, 1'b0, 16'd0, 32'd0, 1'b0);
    send_item(ActClear, '0, 32'd6, 1'b0, 16'd0, 32'd0, 1'b0);
    drain();

    ttl_plan[0] = 16'hffff;
    ttl_plan[1] = 16'd0;
    ttl_plan[2] = 16'($urandom_range(1, 100));
    ttl_plan[3] = 16'd300;
    ttl_plan[4] = 16'($urandom);
    ttl_plan[5] = 16'hffff;
    clock_now = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      write_ttl(ttl_plan[ph]);
      quiet = (ph == 3);
      repeat (72) random_item();
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
